### src/cpu_65816_effective_address_assert.svh
// Assertion macros shared by the effective address block.
`ifndef CPU_65816_EFFECTIVE_ADDRESS_ASSERT_SVH
`define CPU_65816_EFFECTIVE_ADDRESS_ASSERT_SVH

// same-cycle implication
`define CEA_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define CEA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle check failed");

`endif

### src/cpu_ea_pkg.sv
// Types and constants of the effective address block.
package cpu_ea_pkg;

   localparam int MEM_ADDR_BITS_DEF = 17;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef enum logic [4:0] {
      MODE_DP       = 5'd0,
      MODE_DPX      = 5'd1,
      MODE_DPY      = 5'd2,
      MODE_IDP      = 5'd3,
      MODE_IDPX     = 5'd4,
      MODE_IDPY     = 5'd5,
      MODE_ILDP     = 5'd6,
      MODE_ILDPY    = 5'd7,
      MODE_ADDR     = 5'd8,
      MODE_ADDR_PC  = 5'd9,
      MODE_ADDRX    = 5'd10,
      MODE_ADDRY    = 5'd11,
      MODE_IADDR_PC = 5'd12,
      MODE_IADDRX   = 5'd13,
      MODE_ILADDR   = 5'd14,
      MODE_LONG     = 5'd15,
      MODE_LONGX    = 5'd16,
      MODE_SR       = 5'd17,
      MODE_ISRY     = 5'd18,
      MODE_RELB     = 5'd19,
      MODE_RELW     = 5'd20
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [4:0]  mode;
      logic [23:0] operand;
      logic [15:0] dp_reg;
      logic [15:0] x_index;
      logic [15:0] y_index;
      logic [15:0] stack_ptr;
      logic [7:0]  data_bank;
      logic [7:0]  pc_bank;
      logic [15:0] pc_word;
   } req_item_type;

   typedef struct packed {
      logic        is_ptr;
      logic        is_long;
      logic [15:0] ptr_addr;
      logic [23:0] direct;
   } plan_type;

endpackage

### src/cpu_ea_req_if.sv
// Request channel: decode or memory write items.
interface cpu_ea_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [4:0]  mode;
   logic [23:0] operand;
   logic [7:0]  write_byte;
   logic [15:0] dp_reg;
   logic [15:0] x_index;
   logic [15:0] y_index;
   logic [15:0] stack_ptr;
   logic [7:0]  data_bank;
   logic [7:0]  pc_bank;
   logic [15:0] pc_word;

   modport source (output valid, opcode, mode, operand, write_byte, dp_reg, x_index,
                   y_index, stack_ptr, data_bank, pc_bank, pc_word, input ready);
   modport sink (input valid, opcode, mode, operand, write_byte, dp_reg, x_index,
                 y_index, stack_ptr, data_bank, pc_bank, pc_word, output ready);
endinterface

### src/cpu_ea_rsp_if.sv
// Response channel: effective address items.
interface cpu_ea_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] effective_address;

   modport source (output valid, effective_address, input ready);
   modport sink (input valid, effective_address, output ready);
endinterface

### src/cpu_ea_calc.sv
// Mode decode: pointer address, direct address and final address from a pointer.
module cpu_ea_calc (
   input  cpu_ea_pkg::req_item_type item,
   input  logic [23:0]              ptr,
   output cpu_ea_pkg::plan_type     plan,
   output logic [23:0]              final_addr
);
   import cpu_ea_pkg::*;

   logic [15:0] a16;
   logic [15:0] dpa;
   logic [15:0] dpxa;
   logic [15:0] dpya;
   logic [15:0] sra;
   logic [23:0] db_a;
   logic [23:0] pb_a;
   logic [23:0] db_p;

   assign a16  = item.operand[15:0];
   assign dpa  = item.dp_reg + a16;
   assign dpxa = item.dp_reg + item.x_index + a16;
   assign dpya = item.dp_reg + item.y_index + a16;
   assign sra  = item.stack_ptr + {8'h00, item.operand[7:0]};
   assign db_a = {item.data_bank, a16};
   assign pb_a = {item.pc_bank, a16};
   assign db_p = {item.data_bank, ptr[15:0]};

   always_comb begin
      plan = '0;
      case (mode_type'(item.mode))
         MODE_DP:       plan.direct = {8'h00, dpa};
         MODE_DPX:      plan.direct = {8'h00, dpxa};
         MODE_DPY:      plan.direct = {8'h00, dpya};
         MODE_IDP, MODE_IDPY: begin
            plan.is_ptr   = 1'b1;
            plan.ptr_addr = dpa;
         end
         MODE_IDPX: begin
            plan.is_ptr   = 1'b1;
            plan.ptr_addr = dpxa;
         end
         MODE_ILDP, MODE_ILDPY: begin
            plan.is_ptr   = 1'b1;
            plan.is_long  = 1'b1;
            plan.ptr_addr = dpa;
         end
         MODE_ISRY: begin
            plan.is_ptr   = 1'b1;
            plan.ptr_addr = sra;
         end
         MODE_ADDR:     plan.direct = db_a;
         MODE_ADDR_PC:  plan.direct = pb_a;
         MODE_ADDRX:    plan.direct = db_a + {8'h00, item.x_index};
         MODE_ADDRY:    plan.direct = db_a + {8'h00, item.y_index};
         MODE_IADDR_PC: plan.direct = pb_a;
         MODE_IADDRX:   plan.direct = {item.pc_bank, a16 + item.x_index};
         MODE_ILADDR:   plan.direct = item.operand;
         MODE_LONG:     plan.direct = item.operand;
         MODE_LONGX:    plan.direct = item.operand + {8'h00, item.x_index};
         MODE_SR:       plan.direct = {8'h00, sra};
         MODE_RELB:     plan.direct = {item.pc_bank, item.pc_word + 16'd2}
                                      + {{16{item.operand[7]}}, item.operand[7:0]};
         MODE_RELW:     plan.direct = {item.pc_bank, item.pc_word + 16'd3}
                                      + {{8{item.operand[15]}}, item.operand[15:0]};
         default:       plan = '0;
      endcase
   end

   always_comb begin
      case (mode_type'(item.mode))
         MODE_IDP, MODE_IDPX:  final_addr = db_p;
         MODE_IDPY, MODE_ISRY: final_addr = db_p + {8'h00, item.y_index};
         MODE_ILDP:            final_addr = ptr;
         MODE_ILDPY:           final_addr = ptr + {8'h00, item.y_index};
         default:              final_addr = '0;
      endcase
   end

endmodule

### src/cpu_65816_effective_address.sv
// Top level: effective address sequencer around the pointer byte memory.
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    opcode, mode, operand, write_byte, register snapshots
//   rsp_if   out  valid/ready    effective_address
// A write goes to memory; a decode runs CALC, RD1 and RD2 for a pointer, RD3 if long, and FIN.
// The pointer walk uses one synchronous byte read port, one byte per cycle.
// Reset clears the sequencer and the response valid; the memory holds garbage until written.
// A waiting response lets one more item run up to its result; that item then holds the input.
module cpu_65816_effective_address #(
   parameter int MEM_ADDR_BITS = cpu_ea_pkg::MEM_ADDR_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   cpu_ea_req_if.sink   req_if,
   cpu_ea_rsp_if.source rsp_if
);
   import cpu_ea_pkg::*;
`include "cpu_65816_effective_address_assert.svh"

   localparam logic [15:0] IO_LO = 16'h2000;
   localparam logic [15:0] IO_HI = 16'h5fff;

   logic [7:0] mem_q [2**MEM_ADDR_BITS];

   state_type    state_ff, state_in;
   req_item_type item_ff;
   logic [23:0]  ptr_ff;
   logic [7:0]   rd_data_ff;
   logic         io_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [23:0]  rsp_data_ff;

   plan_type     plan;
   logic [23:0]  final_addr;
   logic         req_accept;
   logic         out_free;
   logic         rd_en;
   logic [1:0]   rd_k;
   logic [23:0]  rd_byte_addr;
   logic         io_in;
   logic [7:0]   byte_val;
   logic         load_out;

   cpu_ea_calc u_calc (
      .item       (item_ff),
      .ptr        (ptr_ff),
      .plan       (plan),
      .final_addr (final_addr)
   );

   assign req_accept   = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign rd_byte_addr = {8'h00, plan.ptr_addr} + {22'h0, rd_k};
   assign io_in        = !rd_byte_addr[22] && (rd_byte_addr[15:0] inside {[IO_LO:IO_HI]});
   assign byte_val     = io_ff ? 8'h00 : rd_data_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_accept && req_if.opcode == OP_DECODE) state_in = ST_CALC;
         ST_CALC: state_in = plan.is_ptr ? ST_RD1 : ST_FIN;
         ST_RD1:  state_in = ST_RD2;
         ST_RD2:  state_in = plan.is_long ? ST_RD3 : ST_FIN;
         ST_RD3:  state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      rd_en        = 1'b0;
      rd_k         = 2'd0;
      load_out     = 1'b0;
      case (state_ff)
         ST_IDLE: req_if.ready = !reset;
         ST_CALC: rd_en = plan.is_ptr;
         ST_RD1: begin
            rd_en = 1'b1;
            rd_k  = 2'd1;
         end
         ST_RD2: begin
            rd_en = plan.is_long;
            rd_k  = 2'd2;
         end
         ST_RD3:  rd_en = 1'b0;
         ST_FIN:  load_out = out_free;
         default: req_if.ready = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.mode      <= req_if.mode;
         item_ff.operand   <= req_if.operand;
         item_ff.dp_reg    <= req_if.dp_reg;
         item_ff.x_index   <= req_if.x_index;
         item_ff.y_index   <= req_if.y_index;
         item_ff.stack_ptr <= req_if.stack_ptr;
         item_ff.data_bank <= req_if.data_bank;
         item_ff.pc_bank   <= req_if.pc_bank;
         item_ff.pc_word   <= req_if.pc_word;
      end
      case (state_ff)
         ST_CALC: ptr_ff        <= '0;
         ST_RD1:  ptr_ff[7:0]   <= byte_val;
         ST_RD2:  ptr_ff[15:8]  <= byte_val;
         ST_RD3:  ptr_ff[23:16] <= byte_val;
         default: ptr_ff        <= ptr_ff;
      endcase
      if (load_out) begin
         rsp_data_ff <= plan.is_ptr ? final_addr : plan.direct;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_if.opcode == OP_WRITE) begin
         mem_q[req_if.operand[MEM_ADDR_BITS-1:0]] <= req_if.write_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_byte_addr[MEM_ADDR_BITS-1:0]];
         io_ff      <= io_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.effective_address = rsp_data_ff;

   `CEA_ASSERT_NEXT(a_decode_enters_calc, clock, reset,
      req_accept && req_if.opcode == OP_DECODE, state_ff == ST_CALC)
   `CEA_ASSERT_NOW(a_rd3_only_long, clock, reset,
      state_ff == ST_RD3, plan.is_long && $past(state_ff) == ST_RD2)
   `CEA_ASSERT_NOW(a_reads_only_ptr, clock, reset,
      state_ff == ST_RD1 || state_ff == ST_RD2, plan.is_ptr)
   `CEA_ASSERT_NEXT(a_fin_holds, clock, reset,
      state_ff == ST_FIN && !out_free, state_ff == ST_FIN && rsp_valid_ff)

endmodule

### bench/tb_cpu_65816_effective_address.sv
// Self-checking testbench for the 65816 effective address decoder.
module tb_cpu_65816_effective_address;
   import cpu_ea_pkg::*;

   localparam int          MEM_ADDR_BITS     = MEM_ADDR_BITS_DEF;
   localparam int          MEM_WORDS         = 1 << MEM_ADDR_BITS;
   localparam logic [31:0] ADDR16_MASK       = 32'h0000ffff;
   localparam logic [31:0] ADDR24_MASK       = 32'h00ffffff;
   localparam logic [31:0] IO_DECODE_MASK    = 32'h0040ffff;
   localparam logic [31:0] IO_WINDOW_LO      = 32'h00002000;
   localparam logic [31:0] IO_WINDOW_HI      = 32'h00005fff;
   localparam logic [4:0]  MODE_FIRST_UNUSED = 5'd21;
   localparam logic [4:0]  MODE_LAST_CODE    = 5'd31;
   localparam int          RESET_CYCLES      = 5;
   localparam int          HOLD_OFF_CYCLES   = 400;
   localparam int          TAIL_CYCLES       = 20;
   localparam int          WATCHDOG_LIMIT    = 4000;

   typedef struct packed {
      logic        opcode;
      logic [4:0]  mode;
      logic [23:0] operand;
      logic [7:0]  write_byte;
      logic [15:0] dp_reg;
      logic [15:0] x_index;
      logic [15:0] y_index;
      logic [15:0] stack_ptr;
      logic [7:0]  data_bank;
      logic [7:0]  pc_bank;
      logic [15:0] pc_word;
      logic        has_exp;
      logic [23:0] exp_addr;
   } ea_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cpu_ea_req_if req_if();
   cpu_ea_rsp_if rsp_if();

   cpu_65816_effective_address dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #10 clock = ~clock;

   logic [7:0]  ptr_mem_model [0:MEM_WORDS-1];
   bit          filled_map [0:MEM_WORDS-1];
   ea_row_type  issued_rows [$];
   logic [23:0] expected_addr_q [$];
   ea_row_type  directed_tab [$];

   int  mismatches    = 0;
   int  checked_count = 0;
   int  write_count   = 0;
   int  idle_cycles   = 0;
   bit  src_quiet     = 0;
   bit  quiet_both    = 0;
   bit  hold_off_req  = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] pick_addr();
      case ($urandom_range(0, 9))
         0: return 24'h000000;
         1: return 24'hffffff;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] fetch_ptr_byte(input logic [31:0] addr);
      logic [31:0] win;
      win = addr & IO_DECODE_MASK;
      if (win >= IO_WINDOW_LO && win <= IO_WINDOW_HI) return 8'h00;
      return ptr_mem_model[addr[MEM_ADDR_BITS-1:0]];
   endfunction

   function automatic logic [31:0] fetch_pointer(input logic [31:0] base, input int span);
      logic [31:0] val;
      val = 32'h0;
      for (int i = 0; i < span; i++)
         val = val | (32'(fetch_ptr_byte((base + i) & ADDR24_MASK)) << (8 * i));
      return val;
   endfunction

   function automatic logic [23:0] calc_effective_address(input ea_row_type row);
      logic [31:0] a, a16, d, x, y, s, db, pb, pc, r, off;
      a   = 32'(row.operand);
      a16 = a & ADDR16_MASK;
      d   = 32'(row.dp_reg);
      x   = 32'(row.x_index);
      y   = 32'(row.y_index);
      s   = 32'(row.stack_ptr);
      db  = 32'(row.data_bank) << 16;
      pb  = 32'(row.pc_bank) << 16;
      pc  = 32'(row.pc_word);
      case (row.mode)
         MODE_DP:       r = (d + a16) & ADDR16_MASK;
         MODE_DPX:      r = (d + x + a16) & ADDR16_MASK;
         MODE_DPY:      r = (d + y + a16) & ADDR16_MASK;
         MODE_IDP:      r = db + fetch_pointer((d + a16) & ADDR16_MASK, 2);
         MODE_IDPX:     r = db + fetch_pointer((d + x + a16) & ADDR16_MASK, 2);
         MODE_IDPY:     r = db + fetch_pointer((d + a16) & ADDR16_MASK, 2) + y;
         MODE_ILDP:     r = fetch_pointer((d + a16) & ADDR16_MASK, 3);
         MODE_ILDPY:    r = fetch_pointer((d + a16) & ADDR16_MASK, 3) + y;
         MODE_ADDR:     r = db + a16;
         MODE_ADDR_PC:  r = pb + a16;
         MODE_ADDRX:    r = db + a16 + x;
         MODE_ADDRY:    r = db + a16 + y;
         MODE_IADDR_PC: r = pb + a16;
         MODE_IADDRX:   r = pb + ((a + x) & ADDR16_MASK);
         MODE_ILADDR:   r = a;
         MODE_LONG:     r = a;
         MODE_LONGX:    r = a + x;
         MODE_SR:       r = (s + (a & 32'hff)) & ADDR16_MASK;
         MODE_ISRY:     r = db + fetch_pointer((s + (a & 32'hff)) & ADDR16_MASK, 2) + y;
         MODE_RELB: begin
            off = {{24{a[7]}}, a[7:0]};
            r = pb + ((pc + 32'd2) & ADDR16_MASK) + off;
         end
         MODE_RELW: begin
            off = {{16{a[15]}}, a[15:0]};
            r = pb + ((pc + 32'd3) & ADDR16_MASK) + off;
         end
         default: r = 32'h0;
      endcase
      return r[23:0];
   endfunction

   function automatic int pointer_span(input ea_row_type row, output logic [31:0] base);
      logic [31:0] a16, d, x, s;
      a16  = 32'(row.operand) & ADDR16_MASK;
      d    = 32'(row.dp_reg);
      x    = 32'(row.x_index);
      s    = 32'(row.stack_ptr);
      base = 32'h0;
      case (row.mode)
         MODE_IDP, MODE_IDPY: begin
            base = (d + a16) & ADDR16_MASK;
            return 2;
         end
         MODE_ILDP, MODE_ILDPY: begin
            base = (d + a16) & ADDR16_MASK;
            return 3;
         end
         MODE_IDPX: begin
            base = (d + x + a16) & ADDR16_MASK;
            return 2;
         end
         MODE_ISRY: begin
            base = (s + 32'(row.operand[7:0])) & ADDR16_MASK;
            return 2;
         end
         default: return 0;
      endcase
   endfunction

   function automatic ea_row_type random_row();
      ea_row_type row;
      row            = '0;
      row.opcode     = ($urandom_range(0, 99) < 15) ? OP_WRITE : OP_DECODE;
      row.mode       = ($urandom_range(0, 9) == 0) ?
                       5'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_CODE)) :
                       5'($urandom_range(MODE_DP, MODE_RELW));
      row.operand    = pick_addr();
      row.write_byte = 8'($urandom);
      row.dp_reg     = pick_word();
      row.x_index    = pick_word();
      row.y_index    = pick_word();
      row.stack_ptr  = pick_word();
      row.data_bank  = pick_byte();
      row.pc_bank    = pick_byte();
      row.pc_word    = pick_word();
      return row;
   endfunction

   function automatic ea_row_type row_wr(input logic [23:0] addr, input logic [7:0] data);
      ea_row_type row;
      row            = '0;
      row.opcode     = OP_WRITE;
      row.operand    = addr;
      row.write_byte = data;
      return row;
   endfunction

   function automatic ea_row_type row_dec(input logic [4:0] mode, input logic [23:0] operand,
         input logic [15:0] d, input logic [15:0] x, input logic [15:0] y,
         input logic [15:0] s, input logic [7:0] db, input logic [7:0] pb,
         input logic [15:0] pc, input logic has_exp, input logic [23:0] exp_addr);
      ea_row_type row;
      row           = '0;
      row.opcode    = OP_DECODE;
      row.mode      = mode;
      row.operand   = operand;
      row.dp_reg    = d;
      row.x_index   = x;
      row.y_index   = y;
      row.stack_ptr = s;
      row.data_bank = db;
      row.pc_bank   = pb;
      row.pc_word   = pc;
      row.has_exp   = has_exp;
      row.exp_addr  = exp_addr;
      return row;
   endfunction

   task automatic offer_row(input ea_row_type row);
      int gap;
      gap = src_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.opcode     <= row.opcode;
      req_if.mode       <= row.mode;
      req_if.operand    <= row.operand;
      req_if.write_byte <= row.write_byte;
      req_if.dp_reg     <= row.dp_reg;
      req_if.x_index    <= row.x_index;
      req_if.y_index    <= row.y_index;
      req_if.stack_ptr  <= row.stack_ptr;
      req_if.data_bank  <= row.data_bank;
      req_if.pc_bank    <= row.pc_bank;
      req_if.pc_word    <= row.pc_word;
      issued_rows.push_back(row);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic fill_pointer_bytes(input ea_row_type row);
      logic [31:0] base, addr;
      int          span;
      span = pointer_span(row, base);
      for (int i = 0; i < span; i++) begin
         addr = (base + i) & ADDR24_MASK;
         if (!filled_map[addr[MEM_ADDR_BITS-1:0]]) begin
            filled_map[addr[MEM_ADDR_BITS-1:0]] = 1'b1;
            offer_row(row_wr(addr[23:0], 8'($urandom)));
         end
      end
   endtask

   task automatic send_item(input ea_row_type row);
      if (row.opcode == OP_WRITE)
         filled_map[row.operand[MEM_ADDR_BITS-1:0]] = 1'b1;
      else
         fill_pointer_bytes(row);
      offer_row(row);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_item(random_row());
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (issued_rows.size() != 0 || expected_addr_q.size() != 0) @(posedge clock);
   endtask

   task automatic build_directed();
      directed_tab.push_back(row_wr(24'h000010, 8'h34));
      directed_tab.push_back(row_wr(24'h000011, 8'h12));
      directed_tab.push_back(row_wr(24'h000012, 8'h56));
      directed_tab.push_back(row_dec(MODE_ILDP, 24'h000010, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 8'h00, 8'h00, 16'h0000, 1'b1, 24'h561234));
      // alias of byte 10h through a high bank
      directed_tab.push_back(row_wr(24'hfe0010, 8'hab));
      directed_tab.push_back(row_dec(MODE_IDP, 24'h000010, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 8'h00, 8'h00, 16'h0000, 1'b1, 24'h0012ab));
      // pointer inside the I/O window reads as zero
      directed_tab.push_back(row_dec(MODE_IDP, 24'h002000, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 8'h55, 8'h00, 16'h0000, 1'b1, 24'h550000));
      directed_tab.push_back(row_wr(24'h00ffff, 8'h77));
      directed_tab.push_back(row_wr(24'h010000, 8'h88));
      directed_tab.push_back(row_dec(MODE_IDPY, 24'h00ffff, 16'h0000, 16'h0000, 16'hffff,
                                     16'h0000, 8'hff, 8'h00, 16'h0000, 1'b1, 24'h008876));
      directed_tab.push_back(row_dec(MODE_DP, 24'hffffff, 16'hffff, 16'h0000, 16'h0000,
                                     16'h0000, 8'h00, 8'h00, 16'h0000, 1'b1, 24'h00fffe));
      directed_tab.push_back(row_dec(MODE_DPX, 24'h00ffff, 16'hffff, 16'hffff, 16'h0000,
                                     16'h0000, 8'h00, 8'h00, 16'h0000, 1'b1, 24'h00fffd));
      directed_tab.push_back(row_dec(MODE_DPY, 24'h00ffff, 16'h8000, 16'h0000, 16'h8000,
                                     16'h0000, 8'h00, 8'h00, 16'h0000, 1'b1, 24'h00ffff));
      directed_tab.push_back(row_dec(MODE_ADDR, 24'h00ffff, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 8'hff, 8'h00, 16'h0000, 1'b1, 24'hffffff));
      directed_tab.push_back(row_dec(MODE_ADDRX, 24'h00ffff, 16'h0000, 16'hffff, 16'h0000,
                                     16'h0000, 8'hff, 8'h00, 16'h0000, 1'b1, 24'h00fffe));
      directed_tab.push_back(row_dec(MODE_LONG, 24'hffffff, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 8'h00, 8'h00, 16'h0000, 1'b1, 24'hffffff));
      directed_tab.push_back(row_dec(MODE_LONGX, 24'hffffff, 16'h0000, 16'hffff, 16'h0000,
                                     16'h0000, 8'h00, 8'h00, 16'h0000, 1'b1, 24'h00fffe));
      directed_tab.push_back(row_dec(MODE_SR, 24'h0000ff, 16'h0000, 16'h0000, 16'h0000,
                                     16'hffff, 8'h00, 8'h00, 16'h0000, 1'b1, 24'h0000fe));
      directed_tab.push_back(row_dec(MODE_RELB, 24'h000080, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 8'h00, 8'h00, 16'hfffe, 1'b1, 24'hffff80));
      directed_tab.push_back(row_dec(MODE_RELW, 24'h007fff, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 8'h00, 8'h12, 16'h0000, 1'b1, 24'h128002));
      directed_tab.push_back(row_dec(MODE_FIRST_UNUSED, 24'hffffff, 16'hffff, 16'hffff,
                                     16'hffff, 16'hffff, 8'hff, 8'hff, 16'hffff, 1'b1, 24'h0));
      directed_tab.push_back(row_dec(MODE_LAST_CODE, 24'hffffff, 16'hffff, 16'hffff,
                                     16'hffff, 16'hffff, 8'hff, 8'hff, 16'hffff, 1'b1, 24'h0));
      directed_tab.push_back(row_dec(MODE_IDPX, 24'h0000f0, 16'h1234, 16'h0101, 16'h0000,
                                     16'h0000, 8'h3c, 8'h00, 16'h0000, 1'b0, 24'h0));
      directed_tab.push_back(row_dec(MODE_ILDPY, 24'h00fffe, 16'h0001, 16'h0000, 16'hffff,
                                     16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0, 24'h0));
      directed_tab.push_back(row_dec(MODE_ADDR_PC, 24'h00ffff, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 8'h00, 8'hff, 16'h0000, 1'b0, 24'h0));
      directed_tab.push_back(row_dec(MODE_ADDRY, 24'h00ffff, 16'h0000, 16'h0000, 16'hffff,
                                     16'h0000, 8'hff, 8'h00, 16'h0000, 1'b0, 24'h0));
      directed_tab.push_back(row_dec(MODE_IADDR_PC, 24'h12abcd, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 8'h00, 8'h7e, 16'h0000, 1'b0, 24'h0));
      directed_tab.push_back(row_dec(MODE_IADDRX, 24'hffffff, 16'h0000, 16'h0001, 16'h0000,
                                     16'h0000, 8'h00, 8'hab, 16'h0000, 1'b0, 24'h0));
      directed_tab.push_back(row_dec(MODE_ILADDR, 24'habcdef, 16'h0000, 16'h0000, 16'h0000,
                                     16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0, 24'h0));
      directed_tab.push_back(row_dec(MODE_ISRY, 24'h000020, 16'h0000, 16'h0000, 16'h0001,
                                     16'hfff0, 8'h01, 8'h00, 16'h0000, 1'b0, 24'h0));
   endtask

   // predict on input acceptance, check on output acceptance
   always @(posedge clock) begin
      ea_row_type  row;
      logic [23:0] exp_addr;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_addr_q.size() == 0) begin
               $error("unexpected effective_address item: actual %06h",
                      rsp_if.effective_address);
               mismatches++;
            end else begin
               exp_addr = expected_addr_q.pop_front();
               checked_count++;
               if (rsp_if.effective_address !== exp_addr) begin
                  $error("effective_address mismatch: expected %06h, actual %06h",
                         exp_addr, rsp_if.effective_address);
                  mismatches++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            row = issued_rows.pop_front();
            if (row.opcode == OP_WRITE) begin
               ptr_mem_model[row.operand[MEM_ADDR_BITS-1:0]] = row.write_byte;
               write_count++;
            end else begin
               expected_addr_q.push_back(row.has_exp ? row.exp_addr
                                                     : calc_effective_address(row));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: random ready, held high in quiet runs, one long hold-off on request
   initial begin
      int   stretch;
      logic level;
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            level        = 1'b0;
            stretch      = HOLD_OFF_CYCLES;
            hold_off_req = 0;
         end else if (quiet_both) begin
            level   = 1'b1;
            stretch = 1;
         end else begin
            level   = ($urandom_range(0, 3) != 0);
            stretch = level ? $urandom_range(1, 16) : pick_gap() + 1;
         end
         rsp_if.ready <= level;
         repeat (stretch) @(posedge clock);
      end
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.opcode     = OP_WRITE;
      req_if.mode       = MODE_DP;
      req_if.operand    = '0;
      req_if.write_byte = '0;
      req_if.dp_reg     = '0;
      req_if.x_index    = '0;
      req_if.y_index    = '0;
      req_if.stack_ptr  = '0;
      req_if.data_bank  = '0;
      req_if.pc_bank    = '0;
      req_if.pc_word    = '0;
      for (int i = 0; i < MEM_WORDS; i++) ptr_mem_model[i] = 8'h00;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      build_directed();
      foreach (directed_tab[i]) send_item(directed_tab[i]);
      wait_drained();

      send_random(450);
      wait_drained();

      // hold the result side off while items keep coming
      hold_off_req = 1;
      src_quiet    = 1;
      send_random(80);
      src_quiet    = 0;

      quiet_both = 1;
      src_quiet  = 1;
      send_random(200);
      quiet_both = 0;
      src_quiet  = 0;

      send_random(400);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d effective addresses over all 32 mode codes, with %0d pointer writes,",
               checked_count, write_count);
      $display("random gaps on both sides, a %0d-cycle result hold-off and back-to-back runs.",
               HOLD_OFF_CYCLES);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/cpu_ea_pkg.sv
src/cpu_ea_req_if.sv
src/cpu_ea_rsp_if.sv
src/cpu_ea_calc.sv
src/cpu_65816_effective_address.sv
bench/tb_cpu_65816_effective_address.sv
